// ===== rtl/rdq_pkg.sv =====
// Shared codes and defaults for the ring deque with id search.
package rdq_pkg;

  localparam int DEPTH_DEF        = 64;
  localparam int ID_BITS_DEF      = 16;
  localparam int PAYLOAD_BITS_DEF = 32;

  localparam int CMD_W = 3;
  localparam int ST_W  = 2;

  localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
  localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_PEEK_FRONT = 3'd4;
  localparam logic [CMD_W-1:0] CMD_CONTAINS   = 3'd5;
  localparam logic [CMD_W-1:0] CMD_CLEAR      = 3'd6;

  localparam logic [ST_W-1:0] ST_OK        = 2'd0;
  localparam logic [ST_W-1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [ST_W-1:0] ST_UNDERFLOW = 2'd2;

endpackage

// ===== rtl/rdq_store.sv =====
// Entry memory: one write port, one registered read port.
module rdq_store import rdq_pkg::*; #(
  parameter int DEPTH  = DEPTH_DEF,
  parameter int WIDTH  = ID_BITS_DEF + PAYLOAD_BITS_DEF,
  localparam int IDX_W = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [IDX_W-1:0] waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [IDX_W-1:0] raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/rdq_ctrl.sv =====
// Command sequencer: pointers, count, memory accesses and the id search walk.
module rdq_ctrl import rdq_pkg::*; #(
  parameter int DEPTH        = DEPTH_DEF,
  parameter int ID_BITS      = ID_BITS_DEF,
  parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEF,
  localparam int IDX_W = $clog2(DEPTH),
  localparam int CNT_W = $clog2(DEPTH + 1),
  localparam int ENT_W = ID_BITS + PAYLOAD_BITS,
  localparam int RES_W = ST_W + 1 + ENT_W + CNT_W + 1
) (
  input  logic                    clk,
  input  logic                    rst_n,
  // command beat
  input  logic                    cmd_valid,
  output logic                    cmd_ready,
  input  logic [CMD_W-1:0]        cmd,
  input  logic [ID_BITS-1:0]      cmd_id,
  input  logic [PAYLOAD_BITS-1:0] cmd_payload,
  // memory side
  output logic                    mem_we,
  output logic [IDX_W-1:0]        mem_waddr,
  output logic [ENT_W-1:0]        mem_wdata,
  output logic                    mem_re,
  output logic [IDX_W-1:0]        mem_raddr,
  input  logic [ENT_W-1:0]        mem_rdata,
  // result side
  input  logic                    res_space,
  output logic                    res_load,
  output logic [RES_W-1:0]        res_data
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_SRCH = 2'd2;

  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  logic [1:0]         state_r, state_nxt;
  logic [IDX_W-1:0]   head_r, head_nxt;
  logic [IDX_W-1:0]   tail_r, tail_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [IDX_W-1:0]   ptr_r, ptr_nxt;
  logic [IDX_W-1:0]   left_r, left_nxt;
  logic [ID_BITS-1:0] key_r, key_nxt;

  logic [IDX_W-1:0] head_inc, head_dec, tail_inc, tail_dec, ptr_inc;
  logic             acc, full, emp;

  logic [ST_W-1:0]         r_status;
  logic                    r_found;
  logic [ID_BITS-1:0]      r_id;
  logic [PAYLOAD_BITS-1:0] r_pay;

  logic [ID_BITS-1:0]      rd_id;
  logic [PAYLOAD_BITS-1:0] rd_pay;

  assign head_inc = (head_r == IDX_LAST) ? '0 : head_r + IDX_W'(1);
  assign head_dec = (head_r == '0) ? IDX_LAST : head_r - IDX_W'(1);
  assign tail_inc = (tail_r == IDX_LAST) ? '0 : tail_r + IDX_W'(1);
  assign tail_dec = (tail_r == '0) ? IDX_LAST : tail_r - IDX_W'(1);
  assign ptr_inc  = (ptr_r == IDX_LAST) ? '0 : ptr_r + IDX_W'(1);

  assign full = (cnt_r == CNT_FULL);
  assign emp  = (cnt_r == '0);

  assign rd_id  = mem_rdata[ENT_W-1:PAYLOAD_BITS];
  assign rd_pay = mem_rdata[PAYLOAD_BITS-1:0];

  assign cmd_ready = (state_r == S_IDLE) && res_space;
  assign acc       = cmd_valid && cmd_ready;

  always_comb begin
    state_nxt = state_r;
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    cnt_nxt   = cnt_r;
    ptr_nxt   = ptr_r;
    left_nxt  = left_r;
    key_nxt   = key_r;
    mem_we    = 1'b0;
    mem_waddr = tail_r;
    mem_wdata = {cmd_id, cmd_payload};
    mem_re    = 1'b0;
    mem_raddr = head_r;
    res_load  = 1'b0;
    r_status  = ST_OK;
    r_found   = 1'b0;
    r_id      = '0;
    r_pay     = '0;

    unique case (state_r)
      S_IDLE: begin
        if (acc) begin
          res_load = 1'b1;
          case (cmd)
            CMD_PUSH_FRONT: begin
              if (full) begin
                r_status = ST_OVERFLOW;
              end else begin
                head_nxt  = head_dec;
                mem_we    = 1'b1;
                mem_waddr = head_dec;
                cnt_nxt   = cnt_r + CNT_W'(1);
              end
            end
            CMD_PUSH_BACK: begin
              if (full) begin
                r_status = ST_OVERFLOW;
              end else begin
                tail_nxt  = tail_inc;
                mem_we    = 1'b1;
                mem_waddr = tail_r;
                cnt_nxt   = cnt_r + CNT_W'(1);
              end
            end
            CMD_POP_FRONT: begin
              if (emp) begin
                r_status = ST_UNDERFLOW;
              end else begin
                mem_re    = 1'b1;
                mem_raddr = head_r;
                head_nxt  = head_inc;
                cnt_nxt   = cnt_r - CNT_W'(1);
                res_load  = 1'b0;
                state_nxt = S_READ;
              end
            end
            CMD_POP_BACK: begin
              if (emp) begin
                r_status = ST_UNDERFLOW;
              end else begin
                mem_re    = 1'b1;
                mem_raddr = tail_dec;
                tail_nxt  = tail_dec;
                cnt_nxt   = cnt_r - CNT_W'(1);
                res_load  = 1'b0;
                state_nxt = S_READ;
              end
            end
            CMD_PEEK_FRONT: begin
              if (emp) begin
                r_status = ST_UNDERFLOW;
              end else begin
                mem_re    = 1'b1;
                mem_raddr = head_r;
                res_load  = 1'b0;
                state_nxt = S_READ;
              end
            end
            CMD_CONTAINS: begin
              // empty queue answers not found right away
              if (!emp) begin
                mem_re    = 1'b1;
                mem_raddr = head_r;
                ptr_nxt   = head_inc;
                left_nxt  = IDX_W'(cnt_r - CNT_W'(1));
                key_nxt   = cmd_id;
                res_load  = 1'b0;
                state_nxt = S_SRCH;
              end
            end
            CMD_CLEAR: begin
              cnt_nxt  = '0;
              head_nxt = '0;
              tail_nxt = '0;
            end
            default: begin
            end
          endcase
        end
      end
      S_READ: begin
        res_load  = 1'b1;
        r_id      = rd_id;
        r_pay     = rd_pay;
        state_nxt = S_IDLE;
      end
      S_SRCH: begin
        // one entry compared per cycle, next read issued alongside
        if (rd_id == key_r) begin
          res_load  = 1'b1;
          r_found   = 1'b1;
          state_nxt = S_IDLE;
        end else if (left_r == '0) begin
          res_load  = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = ptr_r;
          ptr_nxt   = ptr_inc;
          left_nxt  = left_r - IDX_W'(1);
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // status | found | id | payload | count | empty, status lowest
  assign res_data = {(cnt_nxt == '0), cnt_nxt, r_pay, r_id, r_found, r_status};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      head_r  <= '0;
      tail_r  <= '0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ptr_r  <= ptr_nxt;
    left_r <= left_nxt;
    key_r  <= key_nxt;
  end

endmodule

// ===== rtl/rdq_outbuf.sv =====
// Two-deep result buffer: a pending slot ahead of the output register.
module rdq_outbuf #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load,
  input  logic [WIDTH-1:0] load_data,
  output logic             space,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [WIDTH-1:0] out_data
);

  logic             pend_v_r, pend_v_nxt;
  logic [WIDTH-1:0] pend_d_r;
  logic             out_v_r, out_v_nxt;
  logic [WIDTH-1:0] out_d_r;
  logic             move;

  assign move  = pend_v_r && (!out_v_r || out_ready);
  assign space = !pend_v_r || move;

  always_comb begin
    pend_v_nxt = pend_v_r;
    if (load) begin
      pend_v_nxt = 1'b1;
    end else if (move) begin
      pend_v_nxt = 1'b0;
    end
    out_v_nxt = out_v_r;
    if (move) begin
      out_v_nxt = 1'b1;
    end else if (out_ready) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      pend_v_r <= pend_v_nxt;
      out_v_r  <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      pend_d_r <= load_data;
    end
    if (move) begin
      out_d_r <= pend_d_r;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_d_r;

endmodule

// ===== rtl/ring_deque_with_id_search.sv =====
// Top level of the ring deque with id search.
//
// Usage:
//  - One command per input beat: in_tuser is the command, in_tdata the id
//    and payload. Each command gives exactly one result beat on the out_
//    channel: out_tuser is the status, out_tdata the found flag, the popped
//    or peeked id and payload, the live count and the empty flag.
//  - Push, clear, failed commands and unused codes load their result into
//    the pending slot on accept; pop and peek first do a registered read
//    of the entry memory; contains walks the live entries from the front
//    to the first match or the last entry. Results then pass on to the
//    output register, which drives out_tvalid.
//  - Push, clear and failures take one beat per cycle while the result
//    buffer has space; pop and peek hold the input until the read is back;
//    contains holds it while it walks the memory one entry per cycle.
//  - Results pass through a pending slot and an output register, so one
//    more command is accepted while a result waits on a stalled receiver;
//    beyond that in_tready drops until out_tready returns.
//  - Reset (rst_n low, synchronous) empties the queue and drops any result
//    in flight. The entry memory is not cleared; only live entries are read.
module ring_deque_with_id_search import rdq_pkg::*; #(
  parameter int DEPTH        = DEPTH_DEF,
  parameter int ID_BITS      = ID_BITS_DEF,
  parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEF,
  localparam int IDX_W   = $clog2(DEPTH),
  localparam int CNT_W   = $clog2(DEPTH + 1),
  localparam int ENT_W   = ID_BITS + PAYLOAD_BITS,
  localparam int IN_DW   = ((ENT_W + 7) / 8) * 8,
  localparam int OUT_RAW = 1 + ENT_W + CNT_W + 1,
  localparam int OUT_DW  = ((OUT_RAW + 7) / 8) * 8,
  localparam int RES_W   = ST_W + OUT_RAW
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [IN_DW-1:0]  in_tdata,   // entry_id, entry_payload, zero pad
  input  logic [CMD_W-1:0]  in_tuser,   // command
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [OUT_DW-1:0] out_tdata,  // found, out_id, out_payload, count,
                                        // empty_res, zero pad
  output logic [ST_W-1:0]   out_tuser   // status
);

  logic             mem_we, mem_re;
  logic [IDX_W-1:0] mem_waddr, mem_raddr;
  logic [ENT_W-1:0] mem_wdata, mem_rdata;

  logic             res_space, res_load;
  logic [RES_W-1:0] res_data, res_out;

  // entry memory; each word is {id, payload}
  rdq_store #(
    .DEPTH (DEPTH),
    .WIDTH (ENT_W)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // pointers, count and the command sequencer
  rdq_ctrl #(
    .DEPTH        (DEPTH),
    .ID_BITS      (ID_BITS),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd_valid   (in_tvalid),
    .cmd_ready   (in_tready),
    .cmd         (in_tuser),
    .cmd_id      (in_tdata[ID_BITS-1:0]),
    .cmd_payload (in_tdata[ENT_W-1:ID_BITS]),
    .mem_we      (mem_we),
    .mem_waddr   (mem_waddr),
    .mem_wdata   (mem_wdata),
    .mem_re      (mem_re),
    .mem_raddr   (mem_raddr),
    .mem_rdata   (mem_rdata),
    .res_space   (res_space),
    .res_load    (res_load),
    .res_data    (res_data)
  );

  // result staging toward the out_ channel
  rdq_outbuf #(
    .WIDTH (RES_W)
  ) u_outbuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (res_load),
    .load_data (res_data),
    .space     (res_space),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (res_out)
  );

  // status sits in the low bits of the result word, the rest maps to tdata
  assign out_tuser = res_out[ST_W-1:0];
  assign out_tdata = OUT_DW'(res_out[RES_W-1:ST_W]);

endmodule

// ===== rtl/rdq_checker.sv =====
// Port-level checks for the ring deque, bound to the top level.
module rdq_checker import rdq_pkg::*; #(
  parameter int DEPTH        = DEPTH_DEF,
  parameter int ID_BITS      = ID_BITS_DEF,
  parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEF,
  localparam int CNT_W   = $clog2(DEPTH + 1),
  localparam int ENT_W   = ID_BITS + PAYLOAD_BITS,
  localparam int OUT_RAW = 1 + ENT_W + CNT_W + 1,
  localparam int OUT_DW  = ((OUT_RAW + 7) / 8) * 8,
  localparam int CNT_LO  = 1 + ENT_W
) (
  input logic              clk,
  input logic              rst_n,
  input logic              out_tvalid,
  input logic              out_tready,
  input logic [OUT_DW-1:0] out_tdata,
  input logic [ST_W-1:0]   out_tuser
);

  logic             found;
  logic [CNT_W-1:0] cnt;
  logic             empty_flag;
  logic [ENT_W-1:0] entry;

  assign found      = out_tdata[0];
  assign entry      = out_tdata[ENT_W:1];
  assign cnt        = out_tdata[CNT_LO+CNT_W-1:CNT_LO];
  assign empty_flag = out_tdata[OUT_RAW-1];

  // a stalled result beat stays offered
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result beat dropped while stalled");

  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (empty_flag == (cnt == '0)))
    else $error("empty flag disagrees with count");

  a_ovf: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == ST_OVERFLOW) |-> (cnt == CNT_W'(DEPTH)) && !found)
    else $error("overflow reported below capacity");

  a_unf: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == ST_UNDERFLOW) |-> empty_flag && (entry == '0) && !found)
    else $error("underflow reported on a non-empty queue");

  a_found: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && found |-> (out_tuser == ST_OK) && !empty_flag && (entry == '0))
    else $error("found set on a bad result");

endmodule

bind ring_deque_with_id_search rdq_checker #(
  .DEPTH        (DEPTH),
  .ID_BITS      (ID_BITS),
  .PAYLOAD_BITS (PAYLOAD_BITS)
) u_rdq_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

// ===== tb/tb.sv =====
// Self-checking testbench for the ring deque with id search.
module tb;
  import rdq_pkg::*;

  localparam int SLOTS     = DEPTH_DEF;
  localparam int SLOT_W    = $clog2(SLOTS);
  localparam int IDW       = ID_BITS_DEF;
  localparam int PAYW      = PAYLOAD_BITS_DEF;
  localparam int IN_BITS   = ((IDW + PAYW + 7) / 8) * 8;
  localparam int CNTW      = $clog2(SLOTS + 1);
  localparam int OUT_BITS  = ((1 + IDW + PAYW + CNTW + 1 + 7) / 8) * 8;
  localparam int MAX_CYCLES = 400000;
  // code 7 has no meaning; the block must answer it and keep its state
  localparam logic [CMD_W-1:0] CMD_UNUSED = 3'd7;

  typedef enum {MODE_FILL, MODE_DRAIN, MODE_MIXED} traffic_t;

  typedef struct packed {
    logic [ST_W-1:0] status;
    logic            found;
    logic [IDW-1:0]  id;
    logic [PAYW-1:0] payload;
    logic [CNTW-1:0] count;
    logic            empty;
  } deque_reply_t;

  // Tracks the deque contents and checks every reply beat in order.
  class ring_deque_scoreboard;
    logic [IDW-1:0]   slot_id [SLOTS];
    logic [PAYW-1:0]  slot_pay [SLOTS];
    logic [$clog2(SLOTS)-1:0] head;
    logic [$clog2(SLOTS)-1:0] tail;
    int unsigned      live;
    deque_reply_t     pending_replies[$];
    int               mismatches;

    function new();
      head = '0;
      tail = '0;
      live = 0;
      mismatches = 0;
    endfunction

    // Any id currently held; used to steer searches toward hits.
    function logic [IDW-1:0] live_id();
      logic [$clog2(SLOTS)-1:0] pos;
      pos = head + SLOT_W'($urandom_range(0, live - 1));
      return slot_id[pos];
    endfunction

    function void note_command(logic [CMD_W-1:0] cmd, logic [IDW-1:0] id,
                               logic [PAYW-1:0] pay);
      deque_reply_t r;
      logic [$clog2(SLOTS)-1:0] walk;
      r = '0;
      case (cmd)
        CMD_PUSH_FRONT: begin
          if (live == SLOTS) r.status = ST_OVERFLOW;
          else begin
            head = head - 1'b1;
            slot_id[head] = id;
            slot_pay[head] = pay;
            live++;
          end
        end
        CMD_PUSH_BACK: begin
          if (live == SLOTS) r.status = ST_OVERFLOW;
          else begin
            slot_id[tail] = id;
            slot_pay[tail] = pay;
            tail = tail + 1'b1;
            live++;
          end
        end
        CMD_POP_FRONT: begin
          if (live == 0) r.status = ST_UNDERFLOW;
          else begin
            r.id = slot_id[head];
            r.payload = slot_pay[head];
            head = head + 1'b1;
            live--;
          end
        end
        CMD_POP_BACK: begin
          if (live == 0) r.status = ST_UNDERFLOW;
          else begin
            tail = tail - 1'b1;
            r.id = slot_id[tail];
            r.payload = slot_pay[tail];
            live--;
          end
        end
        CMD_PEEK_FRONT: begin
          if (live == 0) r.status = ST_UNDERFLOW;
          else begin
            r.id = slot_id[head];
            r.payload = slot_pay[head];
          end
        end
        CMD_CONTAINS: begin
          walk = head;
          for (int i = 0; i < live; i++) begin
            if (slot_id[walk] == id) begin
              r.found = 1'b1;
              break;
            end
            walk = walk + 1'b1;
          end
        end
        CMD_CLEAR: begin
          live = 0;
          head = '0;
          tail = '0;
        end
        default: ;
      endcase
      r.count = live[CNTW-1:0];
      r.empty = (live == 0);
      pending_replies.push_back(r);
    endfunction

    function void check_result(logic [ST_W-1:0] status, logic [OUT_BITS-1:0] data);
      deque_reply_t want;
      deque_reply_t got;
      if (pending_replies.size() == 0) begin
        $error("reply beat with nothing outstanding: status %0d data %h", status, data);
        mismatches++;
        return;
      end
      want = pending_replies.pop_front();
      // tdata from bit 0: found, id, payload, count, empty
      got.status  = status;
      got.found   = data[0];
      got.id      = data[1 +: IDW];
      got.payload = data[1 + IDW +: PAYW];
      got.count   = data[1 + IDW + PAYW +: CNTW];
      got.empty   = data[1 + IDW + PAYW + CNTW];
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        mismatches++;
      end
      if (got.found !== want.found) begin
        $error("found: expected %0d, got %0d", want.found, got.found);
        mismatches++;
      end
      if (got.id !== want.id) begin
        $error("out_id: expected %h, got %h", want.id, got.id);
        mismatches++;
      end
      if (got.payload !== want.payload) begin
        $error("out_payload: expected %h, got %h", want.payload, got.payload);
        mismatches++;
      end
      if (got.count !== want.count) begin
        $error("count: expected %0d, got %0d", want.count, got.count);
        mismatches++;
      end
      if (got.empty !== want.empty) begin
        $error("empty_res: expected %0d, got %0d", want.empty, got.empty);
        mismatches++;
      end
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_tvalid = 1'b0;
  logic                in_tready;
  logic [IN_BITS-1:0]  in_tdata = '0;
  logic [CMD_W-1:0]    in_tuser = '0;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [OUT_BITS-1:0] out_tdata;
  logic [ST_W-1:0]     out_tuser;

  ring_deque_scoreboard deque_sb = new();

  int gap_pct = 0;      // chance per cycle that the sender holds off
  int stall_pct = 0;    // chance per cycle that the receiver stalls
  int send_calm = 0;    // beats left in a gap-free burst
  int recv_calm = 0;    // cycles left in a stall-free stretch
  int unsigned cycles = 0;

  ring_deque_with_id_search u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // receiver: ready moves on the falling edge, beats are taken on the rising one
  always @(negedge clk) begin
    if (recv_calm > 0) begin
      recv_calm--;
      out_tready = 1'b1;
    end else begin
      if ($urandom_range(0, 63) == 0) recv_calm = 24;
      out_tready = ($urandom_range(0, 99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) deque_sb.check_result(out_tuser, out_tdata);
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > MAX_CYCLES) begin
      $display("FAIL ring_deque_with_id_search");
      $finish;
    end
  end

  // One command beat; valid stays high afterwards unless the next beat idles.
  task automatic send_command(input logic [CMD_W-1:0] cmd, input logic [IDW-1:0] id,
                              input logic [PAYW-1:0] pay);
    @(negedge clk);
    if (send_calm > 0) send_calm--;
    else begin
      if ($urandom_range(0, 63) == 0) send_calm = 20;
      while ($urandom_range(0, 99) < gap_pct) begin
        in_tvalid = 1'b0;
        @(negedge clk);
      end
    end
    in_tvalid = 1'b1;
    in_tuser = cmd;
    in_tdata = {{(IN_BITS - IDW - PAYW){1'b0}}, pay, id};
    do @(posedge clk); while (!in_tready);
    deque_sb.note_command(cmd, id, pay);
  endtask

  // sender holds off until every reply is back
  task automatic drain_replies();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (deque_sb.pending_replies.size() != 0) @(posedge clk);
  endtask

  function automatic logic [CMD_W-1:0] pick_command(traffic_t mode);
    int r;
    logic [CMD_W-1:0] c;
    r = $urandom_range(0, 99);
    case (mode)
      MODE_FILL: begin
        if (r < 46) c = CMD_PUSH_FRONT;
        else if (r < 92) c = CMD_PUSH_BACK;
        else if (r < 95) c = CMD_PEEK_FRONT;
        else if (r < 98) c = CMD_CONTAINS;
        else c = CMD_POP_BACK;
      end
      MODE_DRAIN: begin
        if (r < 40) c = CMD_POP_FRONT;
        else if (r < 80) c = CMD_POP_BACK;
        else if (r < 88) c = CMD_PEEK_FRONT;
        else if (r < 96) c = CMD_CONTAINS;
        else if (r < 98) c = CMD_PUSH_BACK;
        else c = CMD_UNUSED;
      end
      default: begin
        c = 3'($urandom_range(0, 7));
        // keep clears rare so the deque holds something most of the time
        if (c == CMD_CLEAR && $urandom_range(0, 3) != 0) c = CMD_PUSH_BACK;
      end
    endcase
    return c;
  endfunction

  // ids: full range, a narrow band for duplicates, or one already held
  function automatic logic [IDW-1:0] pick_id();
    case ($urandom_range(0, 3))
      0, 1: return IDW'($urandom);
      2: return IDW'($urandom_range(0, 7));
      default: return (deque_sb.live != 0) ? deque_sb.live_id() : IDW'($urandom);
    endcase
  endfunction

  task automatic run_segment(traffic_t mode, int beats);
    for (int n = 0; n < beats; n++) send_command(pick_command(mode), pick_id(), PAYW'($urandom));
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: empty-queue failures, extremes, both index wraps, unused code
    send_command(CMD_POP_FRONT,  '0, '0);
    send_command(CMD_POP_BACK,   '0, '0);
    send_command(CMD_PEEK_FRONT, '0, '0);
    send_command(CMD_CONTAINS,   '0, '0);
    send_command(CMD_UNUSED,     '1, '1);
    send_command(CMD_PUSH_FRONT, '0, '0);            // head wraps below zero
    send_command(CMD_PUSH_BACK,  '1, '1);
    send_command(CMD_PUSH_FRONT, 16'h1234, 32'ha5a5_a5a5);
    send_command(CMD_PEEK_FRONT, '1, '1);
    send_command(CMD_CONTAINS,   '1, '0);            // hit at the back
    send_command(CMD_CONTAINS,   '0, '0);            // hit in the middle
    send_command(CMD_CONTAINS,   16'h4321, '0);      // miss over all entries
    send_command(CMD_UNUSED,     16'h5a5a, 32'h5a5a_5a5a);
    send_command(CMD_POP_BACK,   '0, '0);
    send_command(CMD_POP_FRONT,  '0, '0);
    send_command(CMD_CLEAR,      '1, '1);
    send_command(CMD_CONTAINS,   '0, '0);            // nothing live after clear
    send_command(CMD_PUSH_FRONT, 16'h8001, 32'h8000_0001);
    send_command(CMD_POP_BACK,   '0, '0);            // tail wraps below zero
    send_command(CMD_PUSH_BACK,  16'h7ffe, 32'h7fff_fffe);
    send_command(CMD_POP_FRONT,  '0, '0);
    send_command(CMD_PEEK_FRONT, '0, '0);
    drain_replies();

    // four idling phases; fills alternate with drains so full and empty both occur
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 46; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 46; end
        default: begin gap_pct = 22; stall_pct = 22; end
      endcase
      run_segment((phase % 2 == 0) ? MODE_FILL : MODE_DRAIN, 75);
      run_segment(MODE_MIXED, 40);
      drain_replies();
    end

    repeat (80) @(posedge clk);
    if (deque_sb.mismatches == 0 && deque_sb.pending_replies.size() == 0) begin
      $display("PASS ring_deque_with_id_search");
    end else begin
      $display("FAIL ring_deque_with_id_search");
    end
    $finish;
  end

endmodule
